// File: design/mandelbrot_escape_time_core_assert.svh
// Assertion macros for the escape-time core
`ifndef MANDELBROT_ESCAPE_TIME_CORE_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_ASSERT_SVH
// same-cycle implication
`define MET_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define MET_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: design/met_pkg.sv
// Shared types and constants of the escape-time core
package met_pkg;
	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_LIMIT  = 2'd2;

	localparam logic [12:0] WIDTH_RST  = 13'd1000;
	localparam logic [12:0] HEIGHT_RST = 13'd1000;
	localparam logic [15:0] LIMIT_RST  = 16'd1000;

	typedef struct packed {
		logic        done;
		logic [15:0] count;
	} met_iter_stat_t;
endpackage

// File: design/met_div_cell.sv
// One restoring division step; cells chain into a pipelined divider
module met_div_cell import met_pkg::*; #(
	parameter int DW   = 13,
	parameter int DVW  = 44,
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           vld_in,
	input  logic           tag_in,
	input  logic           neg_in,
	input  logic [DW-1:0]  div_in,
	input  logic [DW-1:0]  rem_in,
	input  logic [DVW-1:0] dvd_in,
	input  logic [DVW-1:0] quo_in,
	output logic           vld_out,
	output logic           tag_out,
	output logic           neg_out,
	output logic [DW-1:0]  div_out,
	output logic [DW-1:0]  rem_out,
	output logic [DVW-1:0] dvd_out,
	output logic [DVW-1:0] quo_out
);
	logic [DW:0] rem_ext;
	logic        ge;
	logic [DW:0] rem_sub;

	assign rem_ext = {rem_in, dvd_in[DVW-1-STEP]};
	assign ge      = rem_ext >= {1'b0, div_in};
	assign rem_sub = rem_ext - {1'b0, div_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		tag_out <= tag_in;
		neg_out <= neg_in;
		div_out <= div_in;
		dvd_out <= dvd_in;
		rem_out <= ge ? rem_sub[DW-1:0] : rem_ext[DW-1:0];
		quo_out <= {quo_in[DVW-2:0], ge};
	end
endmodule

// File: design/met_iter.sv
// Escape-time iteration engine for z = z*z + c
module met_iter import met_pkg::*; #(
	parameter int FRAC_BITS = 28
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      ack,
	input  logic signed [FRAC_BITS+3:0] cr,
	input  logic signed [FRAC_BITS+3:0] ci,
	input  logic [15:0]               limit,
	output met_iter_stat_t            stat
);
	localparam int W = FRAC_BITS + 4;
	localparam logic signed [W+5:0] ZMAX = (W+6)'((64'sd1 <<< (W-1)) - 1);
	localparam logic signed [W+5:0] ZMIN = -(W+6)'(64'sd1 <<< (W-1));
	localparam logic [W+3:0] FOUR = (W+4)'(64'd4 << FRAC_BITS);

	logic signed [W-1:0] zr_q, zi_q, cr_q, ci_q;
	logic [15:0]         cnt_q;
	logic                busy_q, phase_q, done_q, neg_ri_q;
	logic [2*W-1:0]      prr_q, pii_q, pri_q;

	logic [W-1:0]        mag_r, mag_i;
	logic [W+2:0]        m_rr, m_ii, m_ri;
	logic signed [W+5:0] rr, ii, ri, zr_n, zi_n;
	logic [W+3:0]        mag2;

	function automatic logic signed [W-1:0] sat(input logic signed [W+5:0] v);
		if (v > ZMAX) return ZMAX[W-1:0];
		if (v < ZMIN) return ZMIN[W-1:0];
		return v[W-1:0];
	endfunction

	assign mag_r = zr_q[W-1] ? W'(-zr_q) : W'(zr_q);
	assign mag_i = zi_q[W-1] ? W'(-zi_q) : W'(zi_q);

	assign m_rr = prr_q[FRAC_BITS+W+2:FRAC_BITS];
	assign m_ii = pii_q[FRAC_BITS+W+2:FRAC_BITS];
	assign m_ri = pri_q[FRAC_BITS+W+2:FRAC_BITS];
	assign rr   = $signed({3'b0, m_rr});
	assign ii   = $signed({3'b0, m_ii});
	assign ri   = neg_ri_q ? -$signed({3'b0, m_ri}) : $signed({3'b0, m_ri});
	assign mag2 = (W+4)'(m_rr) + (W+4)'(m_ii);
	assign zr_n = rr - ii + (W+6)'(cr_q);
	assign zi_n = (ri <<< 1) + (W+6)'(ci_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
		end else if (start) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
			done_q  <= 1'b0;
		end else if (busy_q) begin
			if (!phase_q) begin
				if (cnt_q == limit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					phase_q <= 1'b1;
				end
			end else begin
				phase_q <= 1'b0;
				if (mag2 > FOUR) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end else if (ack) begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zr_q  <= '0;
			zi_q  <= '0;
			cr_q  <= cr;
			ci_q  <= ci;
			cnt_q <= '0;
		end else if (busy_q) begin
			if (!phase_q) begin
				prr_q    <= (2*W)'(mag_r) * (2*W)'(mag_r);
				pii_q    <= (2*W)'(mag_i) * (2*W)'(mag_i);
				pri_q    <= (2*W)'(mag_r) * (2*W)'(mag_i);
				neg_ri_q <= zr_q[W-1] ^ zi_q[W-1];
			end else if (!(mag2 > FOUR)) begin
				zr_q  <= sat(zr_n);
				zi_q  <= sat(zi_n);
				cnt_q <= cnt_q + 16'd1;
			end
		end
	end

	assign stat.done  = done_q;
	assign stat.count = cnt_q;
endmodule

// File: design/mandelbrot_escape_time_core.sv
// A pixel's x and then y coordinate pass through a pipelined coordinate divider of
// (max(12,log2 MAX_DIM)+FRAC_BITS+2) cells (42 by default); the iteration engine then
// loops to limit hit or escape; a pixel is taken only after the last count is loaded.
// A finished count waits in the output register while the next item is taken.
// Reset: arst_n clears control and restores width 1000, height 1000, limit 1000.
`include "mandelbrot_escape_time_core_assert.svh"
module mandelbrot_escape_time_core import met_pkg::*; #(
	parameter int MAX_DIM   = 4096,
	parameter int FRAC_BITS = 28
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pixel_x[11:0], pixel_y[23:12]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // iteration_count[15:0]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int W   = FRAC_BITS + 4;
	localparam int DW  = $clog2(MAX_DIM) + 1;
	localparam int MW  = (DW - 1 > 12) ? DW - 1 : 12;
	localparam int NW  = MW + 1;
	localparam int DVW = MW + FRAC_BITS + 2;
	localparam logic [DVW-1:0] QPOS = DVW'((64'd1 << (W-1)) - 1);
	localparam logic [DVW-1:0] QNEG = DVW'(64'd1 << (W-1));
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_ITER = 2'd2;

	logic [12:0] width_q, height_q;
	logic [15:0] limit_q;
	logic [1:0]  state_q;
	logic        inj_q, out_vld_q, accept, load;
	logic [11:0] py_q;
	logic [15:0] out_q;

	logic [11:0]          coord;
	logic [12:0]          size_reg;
	logic [DW-1:0]        sz;
	logic signed [NW-1:0] n;
	logic [MW-1:0]        mag;

	logic           vld_a [0:DVW];
	logic           tag_a [0:DVW];
	logic           neg_a [0:DVW];
	logic [DW-1:0]  div_a [0:DVW];
	logic [DW-1:0]  rem_a [0:DVW];
	logic [DVW-1:0] dvd_a [0:DVW];
	logic [DVW-1:0] quo_a [0:DVW];

	logic [DVW-1:0]      q_end;
	logic signed [W-1:0] c_map, cr_q;
	logic                start;
	met_iter_stat_t      stat;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			limit_q  <= LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data[12:0];
				CFG_HEIGHT: height_q <= cfg_data[12:0];
				CFG_LIMIT:  limit_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	assign coord    = inj_q ? py_q : s_tdata[11:0];
	assign size_reg = inj_q ? height_q : width_q;
	always_comb begin
		if (size_reg == 13'd0)
			sz = DW'(1);
		else if (32'(size_reg) > 32'(MAX_DIM))
			sz = DW'(MAX_DIM);
		else
			sz = DW'(size_reg);
	end
	assign n   = $signed(NW'(coord)) - $signed(NW'(sz >> 1));
	assign mag = n[NW-1] ? MW'(-n) : MW'(n);

	assign vld_a[0] = accept || inj_q;
	assign tag_a[0] = inj_q;
	assign neg_a[0] = n[NW-1];
	assign div_a[0] = sz;
	assign rem_a[0] = '0;
	assign dvd_a[0] = {mag, (FRAC_BITS+2)'(0)};
	assign quo_a[0] = '0;

	for (genvar g = 0; g < DVW; g++) begin : g_cell
		met_div_cell #(.DW(DW), .DVW(DVW), .STEP(g)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (vld_a[g]),
			.tag_in  (tag_a[g]),
			.neg_in  (neg_a[g]),
			.div_in  (div_a[g]),
			.rem_in  (rem_a[g]),
			.dvd_in  (dvd_a[g]),
			.quo_in  (quo_a[g]),
			.vld_out (vld_a[g+1]),
			.tag_out (tag_a[g+1]),
			.neg_out (neg_a[g+1]),
			.div_out (div_a[g+1]),
			.rem_out (rem_a[g+1]),
			.dvd_out (dvd_a[g+1]),
			.quo_out (quo_a[g+1])
		);
	end

	assign q_end = quo_a[DVW];
	always_comb begin
		if (neg_a[DVW])
			c_map = (q_end > QNEG) ? $signed(QNEG[W-1:0]) : $signed(W'(-q_end));
		else
			c_map = (q_end > QPOS) ? $signed(QPOS[W-1:0]) : $signed(q_end[W-1:0]);
	end

	assign start = vld_a[DVW] && tag_a[DVW];
	assign load  = (state_q == ST_ITER) && stat.done && (!out_vld_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			inj_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			inj_q <= accept;
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_DIV;
				ST_DIV:  if (start) state_q <= ST_ITER;
				ST_ITER: if (load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (load)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			py_q <= s_tdata[23:12];
		if (vld_a[DVW] && !tag_a[DVW])
			cr_q <= c_map;
		if (load)
			out_q <= stat.count;
	end

	met_iter #(.FRAC_BITS(FRAC_BITS)) u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.ack    (load),
		.cr     (cr_q),
		.ci     (c_map),
		.limit  (limit_q),
		.stat   (stat)
	);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	`MET_ASSERT_NEXT(a_accept_div, accept, state_q == ST_DIV && !s_tready)
	`MET_ASSERT_IMPL(a_start_in_div, start, state_q == ST_DIV)
	`MET_ASSERT_NEXT(a_load_out, load, m_tvalid && state_q == ST_IDLE)
endmodule

// File: bench/escape_count_checker.sv
// Checker for the escape-time core: predicts iteration counts and compares results
`timescale 1ns / 100ps
module escape_count_checker import met_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          counts_pending,
	output int          counts_checked
);
	localparam int     FRAC   = 28;
	localparam longint SIZE_MAX = 4096;
	localparam longint FX_HI  = (64'sd1 <<< (FRAC + 3)) - 1;
	localparam longint FX_LO  = -(64'sd1 <<< (FRAC + 3));

	logic [12:0] width_reg;
	logic [12:0] height_reg;
	logic [15:0] limit_reg;
	logic [15:0] count_q[$];

	function automatic longint clamp_q4(longint v);
		if (v > FX_HI) return FX_HI;
		if (v < FX_LO) return FX_LO;
		return v;
	endfunction

	function automatic longint q4_mul(longint a, longint b);
		longint unsigned ma, mb, p;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		p = (ma * mb) >> FRAC;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint pixel_to_plane(logic [11:0] coord, logic [12:0] size_reg);
		longint size, n;
		longint unsigned q;
		size = size_reg;
		if (size < 1) size = 1;
		if (size > SIZE_MAX) size = SIZE_MAX;
		n = longint'(coord) - size / 2;
		q = ($unsigned((n < 0) ? -n : n) << (FRAC + 2)) / size;
		return clamp_q4((n < 0) ? -longint'(q) : longint'(q));
	endfunction

	function automatic logic [15:0] escape_count(logic [11:0] px, logic [11:0] py);
		longint cr, ci, zr, zi, rr, ii, ri;
		int unsigned iters;
		cr = pixel_to_plane(px, width_reg);
		ci = pixel_to_plane(py, height_reg);
		zr = 0;
		zi = 0;
		iters = 0;
		while (iters < limit_reg) begin
			rr = q4_mul(zr, zr);
			ii = q4_mul(zi, zi);
			if (rr + ii > (64'sd4 <<< FRAC)) break;
			ri = q4_mul(zr, zi);
			zr = clamp_q4(rr - ii + cr);
			zi = clamp_q4(2 * ri + ci);
			iters++;
		end
		return iters[15:0];
	endfunction

	assign counts_pending = count_q.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg <= WIDTH_RST;
			height_reg <= HEIGHT_RST;
			limit_reg <= LIMIT_RST;
			mismatches <= 0;
			counts_checked <= 0;
			count_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIDTH: width_reg <= cfg_data[12:0];
					CFG_HEIGHT: height_reg <= cfg_data[12:0];
					CFG_LIMIT: limit_reg <= cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				count_q.push_back(escape_count(s_tdata[11:0], s_tdata[23:12]));
			if (m_tvalid && m_tready) begin
				counts_checked <= counts_checked + 1;
				if (count_q.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual %0d", $time, m_tdata);
					mismatches <= mismatches + 1;
				end else begin
					if (m_tdata !== count_q[0]) begin
						$display("%0t: iteration_count expected %0d, actual %0d",
							$time, count_q[0], m_tdata);
						mismatches <= mismatches + 1;
					end
					void'(count_q.pop_front());
				end
			end
		end
	end
endmodule

// File: bench/mandelbrot_escape_time_core_test.sv
// Testbench top for the escape-time core: stimulus, back-pressure and verdict
`timescale 1ns / 100ps
module mandelbrot_escape_time_core_test;
	import met_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_WIDTH;
	logic [15:0] cfg_data = '0;
	int          mismatches, counts_pending, counts_checked;
	bit          busy_sink = 1'b0;
	bit          steady = 1'b0;
	int          pixels_sent = 0;
	int          settings_used = 0;
	int          width_now = 1000, height_now = 1000;

	always #5 clk = ~clk;

	mandelbrot_escape_time_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	escape_count_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .counts_pending(counts_pending),
		.counts_checked(counts_checked)
	);

	always @(posedge clk) begin
		if (busy_sink)
			m_tready <= 1'b0;
		else
			m_tready <= steady || ($urandom_range(99) >= 31);
	end

	task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
		while (!steady && $urandom_range(99) < 31) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {py, px};
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (counts_pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_view(input int w, input int h, input int lim);
		drain();
		write_reg(CFG_WIDTH, 16'(w));
		write_reg(CFG_HEIGHT, 16'(h));
		write_reg(CFG_LIMIT, 16'(lim));
		width_now = w;
		height_now = h;
		settings_used++;
	endtask

	function automatic logic [11:0] pick_coord(int size);
		int top;
		if ($urandom_range(7) == 0) return 12'($urandom);
		top = (size < 1) ? 0 : ((size > 4096) ? 4095 : size - 1);
		return 12'($urandom_range(top, 0));
	endfunction

	task automatic random_pixels(input int n);
		repeat (n) send_pixel(pick_coord(width_now), pick_coord(height_now));
	endtask

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int w, h;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// reset view: corners, center, axes
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd500, 12'd500);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd250, 12'd500);
		send_pixel(12'd999, 12'd999);
		send_pixel(12'd2730, 12'd1365);

		// zero size, oversize, zero limit, ignored index
		set_view(0, 8191, 0);
		write_reg(2'd3, 16'hFFFF);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd1, 12'd2048);
		set_view(8191, 0, 16);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd2048, 12'd1);
		send_pixel(12'd1000, 12'd0);

		// smallest view and limit
		set_view(4, 4, 1);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd2, 12'd2);
		send_pixel(12'd3, 12'd1);

		// largest view and limit, only quickly escaping points
		set_view(4096, 4096, 65535);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd2048);
		send_pixel(12'd3500, 12'd0);

		// no idling at all
		set_view(32, 32, 24);
		steady = 1'b1;
		random_pixels(100);
		steady = 1'b0;

		// long sink hold while the source keeps offering
		set_view(16, 40, 12);
		fork
			begin
				busy_sink = 1'b1;
				repeat (400) @(posedge clk);
				busy_sink = 1'b0;
			end
		join_none
		random_pixels(100);

		// source pause until everything has drained, mid-stream
		set_view(64, 48, 40);
		random_pixels(50);
		drain();
		random_pixels(50);

		repeat (3) begin
			w = ($urandom_range(4) == 0) ? 4096 : $urandom_range(64, 4);
			h = ($urandom_range(4) == 0) ? 4096 : $urandom_range(64, 4);
			set_view(w, h, $urandom_range(48, 1));
			random_pixels(100);
		end

		drain();
		$display("covered %0d pixels over %0d view settings, %0d counts checked",
			pixels_sent, settings_used + 1, counts_checked);
		$display("included zero and oversize views, limits 0 to 65535, sink hold and source pause");
		if (mismatches == 0 && counts_pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
